/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL of the stack block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define SWM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define SWM_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  `SWM_ASSERT(lbl, clk, rst, cond, msg)

`endif

/* sv/swm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack with middle access: shared definitions
// Sizes, operation and status codes, controller states, the command and status
// bundles that join the controller to the datapath, and word width converters.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int RES_W      = 32;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int MIN_W      = (DATA_WIDTH < RES_W) ? DATA_WIDTH : RES_W;

  typedef enum logic [1:0] {
    OP_PUSH       = 2'd0,
    OP_POP        = 2'd1,
    OP_READ_MID   = 2'd2,
    OP_DELETE_MID = 2'd3
  } op_t;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SHIFT,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_TOP,
    RD_MID,
    RD_DEL_FIRST,
    RD_DEL_NEXT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_PUSH,
    WR_SHIFT
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_DONE,
    RES_EMPTY,
    RES_FULL,
    RES_RDATA
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    cnt_op_t  cnt_op;
    logic     ptr_load;
    logic     ptr_inc;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic del_short;
    logic shift_last;
    logic out_free;
  } stat_t;

  // Sign-extend or truncate a request word to the stored width.
  function automatic logic [DATA_WIDTH-1:0] to_data(input logic [RES_W-1:0] v);
    logic [DATA_WIDTH-1:0] d;
    d = {DATA_WIDTH{v[RES_W-1]}};
    for (int b = 0; b < MIN_W; b++) begin
      d[b] = v[b];
    end
    return d;
  endfunction

  // Zero-extend or truncate a stored word to the result width.
  function automatic logic [RES_W-1:0] to_result(input logic [DATA_WIDTH-1:0] d);
    logic [RES_W-1:0] r;
    r = '0;
    for (int b = 0; b < MIN_W; b++) begin
      r[b] = d[b];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/swm_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack with middle access: channel interfaces
// Valid/ready channels for the operation requests and for the results.
// ----------------------------------------------------------------------------
interface swm_req_if;
  import swm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic signed [RES_W-1:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface swm_res_if;
  import swm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_value;
  logic [1:0]              status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface
`default_nettype wire

/* sv/stack_with_middle_ops.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack with middle access
// A bounded stack of signed words that can also read or delete its middle
// entry (index count/2 from the bottom).
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                        Meaning
//   req      in   operation[1:0], push_value     push, pop, read middle,
//                                                delete middle
//   res      out  result_value[31:0], status     one result per request
//
// Push and an empty-stack request go from execute straight to the hand-off
// to the result register; read middle and a non-empty pop pass a read wait.
// Delete middle on three or more entries moves up to DEPTH/2 - 1 entries
// down in a shift loop set by the single memory read and write port.
// Reset clears the entry count and the control state; the entry memory
// itself is not cleared, since only entries below the count are ever read.
// A new request is taken while an earlier result still waits in the output
// register; a stalled result port holds the block at its hand-off step.
// ----------------------------------------------------------------------------
module stack_with_middle_ops (
  input  logic         clk,
  input  logic         rst,
  swm_req_if.sink      req,
  swm_res_if.source    res
);
  import swm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller walks each request through its steps; it raises ready
  // only when no request is in progress.
  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the entries, the count and the result register that
  // drives the result channel directly.
  swm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (req.operation),
    .push_value   (req.push_value),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .result_value (res.result_value),
    .status       (res.status)
  );

endmodule
`default_nettype wire

/* sv/swm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Stack with middle access: controller
// Sequences one request at a time through execute, read wait, the shift
// loop of a middle delete and the hand-off to the result register.
// ----------------------------------------------------------------------------
module swm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  swm_pkg::stat_t stat,
  output swm_pkg::cmd_t  cmd
);
  import swm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.op)
          OP_POP, OP_READ_MID: begin
            state_next = stat.empty ? S_FIN : S_RDWAIT;
          end
          OP_DELETE_MID: begin
            state_next = (stat.empty || stat.del_short) ? S_FIN : S_SHIFT;
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_RDWAIT: begin
        state_next = S_FIN;
      end
      S_SHIFT: begin
        if (stat.shift_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    cmd      = '0;
    case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        case (stat.op)
          OP_PUSH: begin
            if (stat.full) begin
              cmd.res_sel = RES_FULL;
            end else begin
              cmd.wr_sel  = WR_PUSH;
              cmd.cnt_op  = CNT_INC;
              cmd.res_sel = RES_DONE;
            end
          end
          OP_POP: begin
            if (stat.empty) begin
              cmd.res_sel = RES_EMPTY;
            end else begin
              cmd.rd_sel = RD_TOP;
              cmd.cnt_op = CNT_DEC;
            end
          end
          OP_READ_MID: begin
            if (stat.empty) begin
              cmd.res_sel = RES_EMPTY;
            end else begin
              cmd.rd_sel = RD_MID;
            end
          end
          default: begin
            if (stat.empty) begin
              cmd.res_sel = RES_EMPTY;
            end else if (stat.del_short) begin
              cmd.cnt_op  = CNT_DEC;
              cmd.res_sel = RES_DONE;
            end else begin
              cmd.ptr_load = 1'b1;
              cmd.rd_sel   = RD_DEL_FIRST;
            end
          end
        endcase
      end
      S_RDWAIT: begin
        cmd.res_sel = RES_RDATA;
      end
      S_SHIFT: begin
        cmd.wr_sel  = WR_SHIFT;
        cmd.ptr_inc = 1'b1;
        if (stat.shift_last) begin
          cmd.cnt_op  = CNT_DEC;
          cmd.res_sel = RES_DONE;
        end else begin
          cmd.rd_sel = RD_DEL_NEXT;
        end
      end
      S_FIN: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // A captured request is always executed in the following cycle.
  `SWM_ASSERT(a_capture_exec, clk, rst, (in_valid && in_ready) |=> (state == S_EXEC), "capture not followed by execute")
  // The shift loop leaves only toward the result hand-off.
  `SWM_ASSERT(a_shift_exit, clk, rst, (state == S_SHIFT) |=> (state == S_SHIFT || state == S_FIN), "shift loop left to a wrong state")
  // A result is loaded exactly when the hand-off state ends.
  `SWM_ASSERT(a_load_leaves, clk, rst, cmd.out_load |=> (state == S_IDLE), "result load without return to idle")

endmodule
`default_nettype wire

/* sv/swm_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Stack with middle access: datapath
// Entry memory with one write and one registered read port, entry count,
// shift pointer, result staging and the output register.
// ----------------------------------------------------------------------------
module swm_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  swm_pkg::cmd_t                    cmd,
  output swm_pkg::stat_t                   stat,
  input  logic [1:0]                       operation,
  input  logic signed [swm_pkg::RES_W-1:0] push_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [swm_pkg::RES_W-1:0] result_value,
  output logic [1:0]                       status
);
  import swm_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  op_t                   op;
  logic [DATA_WIDTH-1:0] word;
  logic [CNT_W-1:0]      count;
  logic [AW-1:0]         ptr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [RES_W-1:0]      res_value;
  logic [1:0]            res_status;

  logic [CNT_W-1:0]      top_idx;
  logic [CNT_W-1:0]      mid_idx;
  logic [CNT_W-1:0]      first_src;
  logic [CNT_W-1:0]      next_src;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  assign top_idx   = count - CNT_W'(1);
  assign mid_idx   = count >> 1;
  assign first_src = mid_idx + CNT_W'(1);
  assign next_src  = CNT_W'(ptr) + CNT_W'(2);

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (cmd.rd_sel)
      RD_TOP:       rd_addr = top_idx[AW-1:0];
      RD_MID:       rd_addr = mid_idx[AW-1:0];
      RD_DEL_FIRST: rd_addr = first_src[AW-1:0];
      RD_DEL_NEXT:  rd_addr = next_src[AW-1:0];
      default:      rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = rd_data;
    case (cmd.wr_sel)
      WR_PUSH: begin
        wr_addr = count[AW-1:0];
        wr_data = word;
      end
      WR_SHIFT: begin
        wr_addr = ptr;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_op)
        CNT_INC: count <= count + CNT_W'(1);
        CNT_DEC: count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= op_t'(operation);
      word <= to_data(push_value);
    end
    if (cmd.ptr_load) begin
      ptr <= mid_idx[AW-1:0];
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + AW'(1);
    end
    case (cmd.res_sel)
      RES_DONE: begin
        res_value  <= '0;
        res_status <= ST_DONE;
      end
      RES_EMPTY: begin
        res_value  <= '1;
        res_status <= ST_EMPTY;
      end
      RES_FULL: begin
        res_value  <= '0;
        res_status <= ST_FULL;
      end
      RES_RDATA: begin
        res_value  <= to_result(rd_data);
        res_status <= ST_DONE;
      end
      default: begin
        res_value  <= res_value;
        res_status <= res_status;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_value <= res_value;
      status       <= res_status;
    end
  end

  always_comb begin
    stat.op         = op;
    stat.empty      = (count == '0);
    stat.full       = (count == CNT_W'(DEPTH));
    stat.del_short  = (count < CNT_W'(3));
    stat.shift_last = (next_src >= count);
    stat.out_free   = !out_valid || out_ready;
  end

  `SWM_ASSERT_ALWAYS(a_count_range, clk, rst, count <= CNT_W'(DEPTH), "entry count above depth")
  `SWM_ASSERT_ALWAYS(a_push_room, clk, rst, (cmd.wr_sel != WR_PUSH) || !stat.full, "push write into a full stack")
  `SWM_ASSERT(a_shift_in_range, clk, rst, (cmd.wr_sel == WR_SHIFT) |-> (CNT_W'(ptr) + CNT_W'(1) < count), "shift write outside the live entries")

endmodule
`default_nettype wire
